// ----- sv/mcg_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// mcg_pkg
// Shared types, constants and small functions for the month calendar grid.
// ----------------------------------------------------------------------------
package mcg_pkg;

  localparam int YearW  = 14;
  localparam int MonthW = 4;
  localparam int DayW   = 5;
  localparam int RowW   = 3;
  localparam int ColW   = 3;

  localparam logic [YearW-1:0]  YearMin        = 14'd1;
  localparam logic [YearW-1:0]  YearMax        = 14'd9999;
  localparam logic [MonthW-1:0] MonthJan       = 4'd1;
  localparam logic [MonthW-1:0] MonthFeb       = 4'd2;
  localparam logic [MonthW-1:0] MonthSep       = 4'd9;
  localparam logic [MonthW-1:0] MonthDec       = 4'd12;
  localparam logic [YearW-1:0]  FirstGregYear  = 14'd1752;

  // floor(ay / 100) as (ay * 5243) >> 19, exact for ay below 10000
  localparam int                RecipW         = 13;
  localparam logic [RecipW-1:0] Recip100       = 13'd5243;
  localparam int                RecipShift     = 19;
  localparam int                ProdW          = YearW + RecipW;

  // day 1 plus the 52 * 7 + 6 bias that keeps the Zeller sum positive
  localparam logic [10:0] ZellerBias = 11'd371;
  localparam logic [10:0] JulianEra  = 11'd5;

  localparam logic [DayW-1:0] SkipDay   = 5'd3;
  localparam logic [DayW-1:0] SkipCount = 5'd11;
  localparam logic [RowW-1:0] LastRow   = 3'd5;
  localparam logic [ColW-1:0] LastCol   = 3'd6;

  localparam int QueueDepth = 2;
  localparam int QueuePtrW  = 1;

  // classified request handed from front to back
  typedef struct packed {
    logic            err;
    logic            skip;   // September 1752
    logic [2:0]      first;  // weekday of the 1st, 0 Sunday
    logic [DayW-1:0] len;
  } desc_t;

  function automatic logic [DayW-1:0] month_days(input logic [MonthW-1:0] mo);
    logic [DayW-1:0] d;
    case (mo)
      4'd2:    d = 5'd28;
      4'd4:    d = 5'd30;
      4'd6:    d = 5'd30;
      4'd9:    d = 5'd30;
      4'd11:   d = 5'd30;
      default: d = 5'd31;
    endcase
    return d;
  endfunction

  // 13 * (m + 1) / 5 with March = 3 .. February = 14
  function automatic logic [5:0] zeller_month_term(input logic [MonthW-1:0] mo);
    logic [5:0] t;
    case (mo)
      4'd1:    t = 6'd36;
      4'd2:    t = 6'd39;
      4'd3:    t = 6'd10;
      4'd4:    t = 6'd13;
      4'd5:    t = 6'd15;
      4'd6:    t = 6'd18;
      4'd7:    t = 6'd20;
      4'd8:    t = 6'd23;
      4'd9:    t = 6'd26;
      4'd10:   t = 6'd28;
      4'd11:   t = 6'd31;
      4'd12:   t = 6'd33;
      default: t = 6'd0;
    endcase
    return t;
  endfunction

  // 8 = 1 mod 7, so fold octal digits
  function automatic logic [2:0] mod7(input logic [10:0] x);
    logic [4:0] s1;
    logic [3:0] s2;
    s1 = 5'(x[2:0]) + 5'(x[5:3]) + 5'(x[8:6]) + 5'(x[10:9]);
    s2 = 4'(s1[2:0]) + 4'(s1[4:3]);
    if (s2 >= 4'd7) begin
      s2 = s2 - 4'd7;
    end
    return s2[2:0];
  endfunction

endpackage
`default_nettype wire

// ----- sv/mcg_if.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// mcg_req_if / mcg_cell_if
// Valid/ready channels for requests and grid cells.
// ----------------------------------------------------------------------------
interface mcg_req_if;
  logic        valid;
  logic        ready;
  logic [13:0] year;
  logic [3:0]  month;

  modport source (output valid, year, month, input ready);
  modport sink   (input valid, year, month, output ready);
endinterface

interface mcg_cell_if;
  logic       valid;
  logic       ready;
  logic [4:0] cell_day;
  logic [2:0] cell_row;
  logic [2:0] cell_column;
  logic       range_error;
  logic       last_cell;

  modport source (output valid, cell_day, cell_row, cell_column, range_error, last_cell,
                  input ready);
  modport sink   (input valid, cell_day, cell_row, cell_column, range_error, last_cell,
                  output ready);
endinterface
`default_nettype wire

// ----- sv/mcg_front.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// mcg_front
// Three-stage classifier: range check, century split, Zeller weekday and
// month length. Emits one descriptor per request.
// ----------------------------------------------------------------------------
module mcg_front (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  mcg_req_if.sink            req_i,
  output logic               desc_valid_o,
  input  wire logic          desc_ready_i,
  output mcg_pkg::desc_t     desc_o
);
  import mcg_pkg::*;

  typedef struct packed {
    logic              err;
    logic              greg;      // Gregorian weekday rule
    logic              post_leap; // Gregorian leap rule
    logic              skip;
    logic              feb;
    logic              y4;
    logic [MonthW-1:0] month;
  } flags_t;

  // stage A: raw request
  logic              a_valid_q;
  logic [YearW-1:0]  a_year_q;
  logic [MonthW-1:0] a_month_q;
  // stage B: product
  logic              b_valid_q;
  logic [YearW-1:0]  b_ay_q;
  logic [ProdW-1:0]  b_prod_q;
  flags_t            b_flags_q;
  // stage C: century and year of century
  logic              c_valid_q;
  logic [6:0]        c_cc_q;
  logic [6:0]        c_yy_q;
  flags_t            c_flags_q;

  logic a_en, b_en, c_en;
  assign c_en = !c_valid_q || desc_ready_i;
  assign b_en = !b_valid_q || c_en;
  assign a_en = !a_valid_q || b_en;
  assign req_i.ready = a_en;

  // stage A logic
  flags_t           a_flags;
  logic [YearW-1:0] a_ay;
  logic             a_jf;
  always_comb begin
    a_jf            = (a_month_q == MonthJan) || (a_month_q == MonthFeb);
    a_ay            = a_year_q - YearW'(a_jf);
    a_flags.err     = (a_year_q < YearMin) || (a_year_q > YearMax) ||
                      (a_month_q < MonthJan) || (a_month_q > MonthDec);
    a_flags.post_leap = a_year_q > FirstGregYear;
    a_flags.greg    = (a_year_q > FirstGregYear) ||
                      ((a_year_q == FirstGregYear) && (a_month_q > MonthSep));
    a_flags.skip    = (a_year_q == FirstGregYear) && (a_month_q == MonthSep);
    a_flags.feb     = a_month_q == MonthFeb;
    a_flags.y4      = a_year_q[1:0] == 2'b00;
    a_flags.month   = a_month_q;
  end

  // stage B logic
  logic [7:0] b_cc_w;
  logic [6:0] b_cc;
  logic [YearW-1:0] b_yy_w;
  always_comb begin
    b_cc_w = b_prod_q[RecipShift +: 8];
    b_cc   = b_cc_w[6:0];
    b_yy_w = b_ay_q - ((YearW'(b_cc) << 6) + (YearW'(b_cc) << 5) + (YearW'(b_cc) << 2));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q <= 1'b0;
      b_valid_q <= 1'b0;
      c_valid_q <= 1'b0;
    end else begin
      if (a_en) a_valid_q <= req_i.valid;
      if (b_en) b_valid_q <= a_valid_q;
      if (c_en) c_valid_q <= b_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (a_en) begin
      a_year_q  <= req_i.year;
      a_month_q <= req_i.month;
    end
    if (b_en) begin
      b_ay_q    <= a_ay;
      b_prod_q  <= ProdW'(a_ay) * ProdW'(Recip100);
      b_flags_q <= a_flags;
    end
    if (c_en) begin
      c_cc_q    <= b_cc;
      c_yy_q    <= b_yy_w[6:0];
      c_flags_q <= b_flags_q;
    end
  end

  // stage C logic: Zeller sum mod 7 and month length
  logic [10:0] base, zsum;
  logic        leap;
  always_comb begin
    base = 11'(zeller_month_term(c_flags_q.month)) + 11'(c_yy_q) + 11'(c_yy_q[6:2]) +
           ZellerBias;
    if (c_flags_q.greg) begin
      zsum = base + 11'(c_cc_q[6:2]) - 11'({c_cc_q, 1'b0});
    end else begin
      zsum = base + JulianEra - 11'(c_cc_q);
    end
    // for February the split is of year - 1: a century year shows as 99
    if (c_flags_q.post_leap) begin
      leap = c_flags_q.y4 && ((c_yy_q != 7'd99) || (c_cc_q[1:0] == 2'b11));
    end else begin
      leap = c_flags_q.y4;
    end
    desc_o.err   = c_flags_q.err;
    desc_o.skip  = c_flags_q.skip;
    desc_o.first = mod7(zsum);
    if (c_flags_q.feb) begin
      desc_o.len = leap ? 5'd29 : 5'd28;
    end else begin
      desc_o.len = month_days(c_flags_q.month);
    end
  end

  assign desc_valid_o = c_valid_q;

endmodule
`default_nettype wire

// ----- sv/mcg_queue.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// mcg_queue
// Small descriptor FIFO between the classifier and the grid walker.
// ----------------------------------------------------------------------------
module mcg_queue (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          push_valid_i,
  output logic               push_ready_o,
  input  mcg_pkg::desc_t     push_data_i,
  output logic               pop_valid_o,
  input  wire logic          pop_ready_i,
  output mcg_pkg::desc_t     pop_data_o
);
  import mcg_pkg::*;

  desc_t                mem_q [QueueDepth];
  logic [QueuePtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [QueuePtrW:0]   count_q, count_d;
  logic                 push, pop;

  assign push_ready_o = count_q != (QueuePtrW + 1)'(QueueDepth);
  assign pop_valid_o  = count_q != '0;
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_ready_i && pop_valid_o;
  assign pop_data_o   = mem_q[rd_ptr_q];

  always_comb begin
    count_d = count_q;
    if (push && !pop) begin
      count_d = count_q + 1'b1;
    end else if (pop && !push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      count_q <= count_d;
      if (push) wr_ptr_q <= wr_ptr_q + 1'b1;
      if (pop)  rd_ptr_q <= rd_ptr_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule
`default_nettype wire

// ----- sv/mcg_back.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// mcg_back
// Grid walker: steps row and column over the 42 cells of one descriptor, or
// one error cell if it is out of range, and drives the registered cell output.
// ----------------------------------------------------------------------------
module mcg_back (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          desc_valid_i,
  output logic               desc_ready_o,
  input  mcg_pkg::desc_t     desc_i,
  mcg_cell_if.source         cell_o
);
  import mcg_pkg::*;

  logic            busy_q, busy_d;
  desc_t           desc_q;
  logic [RowW-1:0] row_q, row_d;
  logic [ColW-1:0] col_q, col_d;
  logic [DayW:0]   day_q, day_d;   // runs one past the month length

  logic            out_valid_q, out_valid_d;
  logic [DayW-1:0] out_day_q;
  logic [RowW-1:0] out_row_q;
  logic [ColW-1:0] out_col_q;
  logic            out_err_q, out_last_q;

  logic            emit, last, blank, load;
  logic [DayW:0]   day_eff;

  assign emit = busy_q && (!out_valid_q || cell_o.ready);
  assign last = desc_q.err || ((row_q == LastRow) && (col_q == LastCol));
  assign load = desc_valid_i && (!busy_q || (emit && last));
  assign desc_ready_o = load;

  always_comb begin
    blank   = (day_q > (DayW + 1)'(desc_q.len)) ||
              ((row_q == '0) && (3'(col_q) < desc_q.first));
    day_eff = (desc_q.skip && (day_q == (DayW + 1)'(SkipDay)))
              ? day_q + (DayW + 1)'(SkipCount) : day_q;

    busy_d = busy_q;
    row_d  = row_q;
    col_d  = col_q;
    day_d  = day_q;
    if (emit) begin
      if (!blank) begin
        day_d = day_eff + 1'b1;
      end
      if (col_q == LastCol) begin
        col_d = '0;
        row_d = row_q + 1'b1;
      end else begin
        col_d = col_q + 1'b1;
      end
      if (last) begin
        busy_d = 1'b0;
      end
    end
    if (load) begin
      busy_d = 1'b1;
      row_d  = '0;
      col_d  = '0;
      day_d  = (DayW + 1)'(1);
    end

    out_valid_d = out_valid_q;
    if (emit) begin
      out_valid_d = 1'b1;
    end else if (cell_o.ready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      busy_q      <= busy_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    row_q <= row_d;
    col_q <= col_d;
    day_q <= day_d;
    if (load) begin
      desc_q <= desc_i;
    end
    if (emit) begin
      if (desc_q.err) begin
        out_day_q <= '0;
        out_row_q <= '0;
        out_col_q <= '0;
      end else begin
        out_day_q <= blank ? '0 : day_eff[DayW-1:0];
        out_row_q <= row_q;
        out_col_q <= col_q;
      end
      out_err_q  <= desc_q.err;
      out_last_q <= last;
    end
  end

  assign cell_o.valid       = out_valid_q;
  assign cell_o.cell_day    = out_day_q;
  assign cell_o.cell_row    = out_row_q;
  assign cell_o.cell_column = out_col_q;
  assign cell_o.range_error = out_err_q;
  assign cell_o.last_cell   = out_last_q;

endmodule
`default_nettype wire

// ----- sv/month_calendar_grid.sv -----
`default_nettype none
// Throughput: one cell per cycle from the grid walker while cell_o.ready is
// high, giving 42 cells per valid request and one cell per out-of-range request;
// the walker sets the rate.
// The classifier runs ahead of the walker through a two-entry descriptor queue.
// Reset (rst_ni, asynchronous, active low) empties the pipeline, queue and output.
// ----------------------------------------------------------------------------
// month_calendar_grid
// Emits the 6-by-7 Sunday-first day grid of a month, Julian/Gregorian 1752.
// ----------------------------------------------------------------------------
module month_calendar_grid (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  mcg_req_if.sink   req_i,
  mcg_cell_if.source cell_o
);
  import mcg_pkg::*;

  logic  fq_valid, fq_ready;
  desc_t fq_desc;
  logic  qb_valid, qb_ready;
  desc_t qb_desc;

  mcg_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .req_i        (req_i),
    .desc_valid_o (fq_valid),
    .desc_ready_i (fq_ready),
    .desc_o       (fq_desc)
  );

  mcg_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (fq_valid),
    .push_ready_o (fq_ready),
    .push_data_i  (fq_desc),
    .pop_valid_o  (qb_valid),
    .pop_ready_i  (qb_ready),
    .pop_data_o   (qb_desc)
  );

  mcg_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .desc_valid_i (qb_valid),
    .desc_ready_o (qb_ready),
    .desc_i       (qb_desc),
    .cell_o       (cell_o)
  );

endmodule
`default_nettype wire

// ----- bench/month_calendar_grid_tb.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// month_calendar_grid_tb
// Drives year/month requests into the month calendar grid. Each accepted
// request is expanded into its expected 42 cells, or into one range error,
// by a local calendar model. Each returned cell is compared field by field
// with the oldest expected cell. Both channels idle at random unless calm is set.
// ----------------------------------------------------------------------------
module month_calendar_grid_tb;
  import mcg_pkg::*;

  localparam int SwitchYear = FirstGregYear;
  localparam int DrainCycles = 20;

  typedef struct packed {
    logic [DayW-1:0] day;
    logic [RowW-1:0] row;
    logic [ColW-1:0] col;
    logic            err;
    logic            last;
  } grid_cell_t;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  mcg_req_if  req_if ();
  mcg_cell_if cell_if ();

  month_calendar_grid i_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_if),
    .cell_o (cell_if)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  grid_cell_t  expected_cells_q[$];
  int unsigned n_mismatch = 0;
  bit          calm       = 1'b0;  // no idling on either side while set

  function automatic int draw_wait();
    return calm ? 0 : $urandom_range(0, 19);
  endfunction

  function automatic bit is_leap(int y);
    if (y <= SwitchYear) begin
      return (y % 4) == 0;
    end
    return (y % 4) == 0 && ((y % 100) != 0 || (y % 400) == 0);
  endfunction

  function automatic int month_length(int y, int mo);
    int len_tab [12] = '{31, 28, 31, 30, 31, 30, 31, 31, 30, 31, 30, 31};
    if (mo == MonthFeb && is_leap(y)) begin
      return 29;
    end
    return len_tab[mo - 1];
  endfunction

  // Zeller on the 1st of the month, 0 Sunday. Jan/Feb count in the previous
  // year, but the calendar is picked from the real date.
  function automatic int first_weekday(int y, int mo);
    int ay;
    int yy;
    int cc;
    int mm;
    int era;
    bit greg;
    ay   = y - ((mo + 21) / 12) % 2;
    yy   = ay % 100;
    cc   = (ay / 100) % 100;
    mm   = 3 + (9 + mo) % 12;
    greg = (y > SwitchYear) || (y == SwitchYear && mo > MonthSep);
    era  = greg ? (cc / 4 - 2 * cc) : (5 - cc);
    return (1 + 13 * (mm + 1) / 5 + yy + yy / 4 + era + 52 * 7 + 6) % 7;
  endfunction

  task automatic predict_month_grid(int y, int mo);
    grid_cell_t c;
    int len;
    int first;
    int day;
    if (y < YearMin || y > YearMax || mo < MonthJan || mo > MonthDec) begin
      c = '{day: '0, row: '0, col: '0, err: 1'b1, last: 1'b1};
      expected_cells_q.push_back(c);
    end else begin
      len   = month_length(y, mo);
      first = first_weekday(y, mo);
      day   = 1;
      for (int r = 0; r < 6; r++) begin
        for (int k = 0; k < 7; k++) begin
          c.day = '0;
          if (day <= len && !(r == 0 && k < first)) begin
            // September 1752 jumps from the 2nd to the 14th
            if (y == SwitchYear && mo == MonthSep && day == SkipDay) begin
              day += SkipCount;
            end
            c.day = DayW'(day);
            day++;
          end
          c.row  = RowW'(r);
          c.col  = ColW'(k);
          c.err  = 1'b0;
          c.last = (c.row == LastRow) && (c.col == LastCol);
          expected_cells_q.push_back(c);
        end
      end
    end
  endtask

  task automatic report_mismatch(string msg);
    n_mismatch++;
    $display("[%0t] mismatch: %s", $realtime, msg);
  endtask

  task automatic send_request(int y, int mo);
    int gap;
    gap = draw_wait();
    if (gap > 0) begin
      req_if.valid <= 1'b0;
      req_if.year  <= YearW'($urandom);
      req_if.month <= MonthW'($urandom);
      repeat (gap) @(posedge clk_i);
    end
    req_if.valid <= 1'b1;
    req_if.year  <= YearW'(y);
    req_if.month <= MonthW'(mo);
    do @(posedge clk_i); while (!(req_if.valid && req_if.ready));
    predict_month_grid(y, mo);
  endtask

  // result sink: a fresh random stall, possibly none, before every transaction
  initial begin : cell_sink
    int stall;
    forever begin
      stall = draw_wait();
      if (stall > 0) begin
        cell_if.ready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      cell_if.ready <= 1'b1;
      do @(posedge clk_i); while (!(cell_if.valid && cell_if.ready));
    end
  end

  always @(posedge clk_i) begin : cell_check
    grid_cell_t got;
    grid_cell_t want;
    if (rst_ni && cell_if.valid && cell_if.ready) begin
      got = '{day: cell_if.cell_day, row: cell_if.cell_row, col: cell_if.cell_column,
              err: cell_if.range_error, last: cell_if.last_cell};
      if (expected_cells_q.size() == 0) begin
        report_mismatch($sformatf("unexpected cell day %0d row %0d col %0d err %0b",
                                  got.day, got.row, got.col, got.err));
      end else begin
        want = expected_cells_q.pop_front();
        if (got.day !== want.day)
          report_mismatch($sformatf("cell_day %0d, want %0d (row %0d col %0d)",
                                    got.day, want.day, want.row, want.col));
        if (got.row !== want.row)
          report_mismatch($sformatf("cell_row %0d, want %0d", got.row, want.row));
        if (got.col !== want.col)
          report_mismatch($sformatf("cell_column %0d, want %0d (row %0d)",
                                    got.col, want.col, want.row));
        if (got.err !== want.err)
          report_mismatch($sformatf("range_error %0b, want %0b", got.err, want.err));
        if (got.last !== want.last)
          report_mismatch($sformatf("last_cell %0b, want %0b (row %0d col %0d)",
                                    got.last, want.last, want.row, want.col));
      end
    end
  end

  task automatic test_range_errors();
    send_request(0, 1);
    send_request(10000, 6);
    send_request(16383, 12);
    send_request(2024, 0);
    send_request(2024, 13);
    send_request(1, 15);
    send_request(0, 0);
  endtask

  task automatic test_year_extremes();
    send_request(1, 1);
    send_request(1, 12);
    send_request(9999, 1);
    send_request(9999, 12);
  endtask

  task automatic test_calendar_switch();
    send_request(SwitchYear, MonthSep);
    send_request(SwitchYear, 8);
    send_request(SwitchYear, 10);
    send_request(SwitchYear + 1, MonthJan);
    send_request(SwitchYear + 1, MonthFeb);
    send_request(SwitchYear, MonthFeb);
  endtask

  task automatic test_leap_rules();
    send_request(1700, MonthFeb);  // Julian leap
    send_request(1800, MonthFeb);
    send_request(1900, MonthFeb);
    send_request(2000, MonthFeb);
    send_request(2024, MonthFeb);
    send_request(2023, MonthFeb);
  endtask

  task automatic test_random_months(int n);
    int r;
    int y;
    int mo;
    for (int i = 0; i < n; i++) begin
      calm = (i >= n / 3) && (i < n / 3 + 30);
      r  = $urandom_range(0, 99);
      mo = $urandom_range(MonthJan, MonthDec);
      if (r < 12) begin
        // raw field noise, mostly out of range
        y  = $urandom_range(0, (1 << YearW) - 1);
        mo = $urandom_range(0, (1 << MonthW) - 1);
      end else if (r < 30) begin
        y = $urandom_range(SwitchYear - 12, SwitchYear + 12);
      end else if (r < 40) begin
        y = 100 * $urandom_range(1, 99);
      end else begin
        y = $urandom_range(YearMin, YearMax);
      end
      send_request(y, mo);
    end
    calm = 1'b0;
  endtask

  initial begin : run
    req_if.valid <= 1'b0;
    req_if.year  <= '0;
    req_if.month <= '0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;

    test_range_errors();
    test_year_extremes();
    test_calendar_switch();
    test_leap_rules();
    test_random_months(197);

    req_if.valid <= 1'b0;
    while (expected_cells_q.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    if (n_mismatch == 0) begin
      $display("month_calendar_grid verification clean");
    end else begin
      $display("month_calendar_grid verification failed");
    end
    $finish;
  end

  initial begin : watchdog
    #8000000;
    $display("month_calendar_grid verification failed");
    $finish;
  end

endmodule
`default_nettype wire

// ----- files.f -----
sv/mcg_pkg.sv
sv/mcg_if.sv
sv/mcg_front.sv
sv/mcg_queue.sv
sv/mcg_back.sv
sv/month_calendar_grid.sv
bench/month_calendar_grid_tb.sv
